// ===== sv/ppmp_pkg.sv =====
// Shared types, codes and fixed-point helpers for the projected point mask probe.
package ppmp_pkg;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_REVOLVE = 2'd1;
  localparam logic [1:0] CMD_ORTHO   = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ROOT_X       = 3'd2;
  localparam logic [2:0] REG_ROOT_Y       = 3'd3;
  localparam logic [2:0] REG_INV_SCALE    = 3'd4;

  localparam int WIN_STRICT  = 1;
  localparam int WIN_LENIENT = 20;

  // 32767 pixels in Q.16
  localparam logic signed [42:0] SAT_Q16 = 43'sd2147418112;

  localparam int ROOT_STEPS = 32;

  // ceil(2^34 / 5) = 0xCCCCCCCD, split to fit the 24-bit multiplier port
  localparam logic [23:0] RECIP5_HI = 24'h0000CC;
  localparam logic [23:0] RECIP5_LO = 24'hCCCCCD;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_ADD,
    ST_ROOT,
    ST_PREP,
    ST_DIV_LO,
    ST_DIV_HI,
    ST_DIV_SUM,
    ST_MUL_U,
    ST_MUL_V,
    ST_PLACE,
    ST_WIN,
    ST_CLIP,
    ST_MASK,
    ST_SCAN,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  // Apply sign to a Q.16 magnitude, add the origin in pixels, saturate.
  function automatic logic signed [31:0] place_q16(input logic [39:0] m, input logic neg,
                                                   input logic signed [10:0] root);
    logic signed [42:0] t;
    t = $signed({3'b000, m});
    if (neg) begin
      t = -t;
    end
    t = t + $signed({{16{root[10]}}, root, 16'h0000});
    if (t > SAT_Q16) begin
      t = SAT_Q16;
    end
    if (t < -SAT_Q16) begin
      t = -SAT_Q16;
    end
    return t[31:0];
  endfunction

endpackage

// ===== sv/ppmp_mask_mem.sv =====
// One-bit mask store: pixel writes, whole-row registered reads.
module ppmp_mask_mem #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_HEIGHT)-1:0] wr_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_col,
  input  logic                          wr_bit,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_HEIGHT)-1:0] rd_row,
  output logic [MAX_WIDTH-1:0]          rd_data
);

  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][wr_col] <= wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

// ===== sv/projected_point_mask_probe.sv =====
// Projects a query point onto a stored one-bit mask and tests a 3x3 or 41x41 window for set pixels.
// A pixel write (cmd 0) goes into the mask store while the sequencer stays idle. A query runs
// through one shared 32x24 multiplier under a sequencer: revolution mode adds divide states when
// |y| > |x| (scale by 6/5 as r + r/5, r/5 from two reciprocal products after the 32-step
// bit-serial root), and a 41x41 window can scan more mask rows than a 3x3 one, since the scan
// reads one mask row per cycle from the row-wide memory port. Orthographic mode skips the squares
// and the root. A query with inv_scale zero goes straight to the finish state.
// The result waits in an output register.
module projected_point_mask_probe #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic [8:0]          pixel_col,
  input  logic [8:0]          pixel_row,
  input  logic [7:0]          pixel_value,
  input  logic signed [23:0]  point_x,
  input  logic signed [23:0]  point_y,
  input  logic signed [23:0]  point_z,
  input  logic                lenient,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                inside_res,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  import ppmp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  state_t state, state_next;

  logic [9:0]         image_width, image_height;
  logic signed [10:0] root_x, root_y;
  logic [23:0]        inv_scale;

  logic [23:0] ax, ay, az;
  logic        xneg, zpos, y_big, revolve, wide;
  logic        hit, pend;

  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] prod;
  logic [47:0] sum;

  logic [63:0] sq_n, sq_res, sq_bit, sq_t;
  logic [55:0] div_lo;
  logic [63:0] div_sum;
  logic [5:0]  cnt;
  logic [31:0] r;
  logic [39:0] um;
  logic signed [31:0] u, v;

  logic signed [16:0] clo, chi, rlo, rhi;
  logic signed [16:0] w_eff, h_eff, clo_c, chi_c, rlo_c, rhi_c;
  logic signed [32:0] k16;
  logic [CW-1:0] col_lo, col_hi;
  logic [RW-1:0] row_ptr, row_hi;
  logic [MAX_WIDTH-1:0] colmask, colmask_next, rd_data;

  logic          mem_wr_en, mem_rd_en, accept, load_out;
  logic [RW-1:0] mem_wr_row;
  logic [CW-1:0] mem_wr_col;

  function automatic logic signed [16:0] trunc16(input logic signed [32:0] t);
    logic [32:0] m;
    m = t[32] ? 33'(-t) : 33'(t);
    return t[32] ? -$signed(17'(m >> 16)) : $signed(17'(m >> 16));
  endfunction

  assign accept = in_valid && !in_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd) inside
            CMD_REVOLVE, CMD_ORTHO: begin
              if (inv_scale == 24'd0) begin
                state_next = ST_FINISH;
              end else if (cmd == CMD_REVOLVE) begin
                state_next = ST_SQ_X;
              end else begin
                state_next = ST_MUL_U;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SQ_X:    state_next = ST_SQ_Y;
      ST_SQ_Y:    state_next = ST_SQ_ADD;
      ST_SQ_ADD:  state_next = ST_ROOT;
      ST_ROOT:    state_next = (cnt == 6'(ROOT_STEPS - 1)) ? ST_PREP : ST_ROOT;
      ST_PREP:    state_next = y_big ? ST_DIV_LO : ST_MUL_U;
      ST_DIV_LO:  state_next = ST_DIV_HI;
      ST_DIV_HI:  state_next = ST_DIV_SUM;
      ST_DIV_SUM: state_next = ST_MUL_U;
      ST_MUL_U:   state_next = ST_MUL_V;
      ST_MUL_V:   state_next = ST_PLACE;
      ST_PLACE:   state_next = ST_WIN;
      ST_WIN:     state_next = ST_CLIP;
      ST_CLIP: begin
        if (clo_c > chi_c || rlo_c > rhi_c) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_MASK;
        end
      end
      ST_MASK:   state_next = ST_SCAN;
      ST_SCAN:   state_next = (row_ptr == row_hi) ? ST_FLUSH : ST_SCAN;
      ST_FLUSH:  state_next = ST_FINISH;
      ST_FINISH: state_next = (!out_valid || !out_stall) ? ST_IDLE : ST_FINISH;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    mem_rd_en = 1'b0;
    load_out  = 1'b0;
    mul_a     = 32'd0;
    mul_b     = 24'd0;
    unique case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_SQ_X: begin
        mul_a = 32'(ax);
        mul_b = ax;
      end
      ST_SQ_Y: begin
        mul_a = 32'(ay);
        mul_b = ay;
      end
      ST_DIV_LO: begin
        mul_a = r;
        mul_b = RECIP5_LO;
      end
      ST_DIV_HI: begin
        mul_a = r;
        mul_b = RECIP5_HI;
      end
      ST_MUL_U: begin
        mul_a = revolve ? r : 32'(ax);
        mul_b = inv_scale;
      end
      ST_MUL_V: begin
        mul_a = 32'(az);
        mul_b = inv_scale;
      end
      ST_SCAN:   mem_rd_en = 1'b1;
      ST_FINISH: load_out = !out_valid || !out_stall;
      default:   in_stall = 1'b1;
    endcase
  end

  assign mem_wr_en  = accept && cmd == CMD_WRITE && 32'(pixel_col) < MAX_WIDTH
                      && 32'(pixel_row) < MAX_HEIGHT;
  assign mem_wr_row = RW'(pixel_row);
  assign mem_wr_col = CW'(pixel_col);

  ppmp_mask_mem #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_row (mem_wr_row),
    .wr_col (mem_wr_col),
    .wr_bit (pixel_value != 8'd0),
    .rd_en  (mem_rd_en),
    .rd_row (row_ptr),
    .rd_data(rd_data)
  );

  // root step; r * 0xCCCCCCCD from the high and low partial products, r/5 = bits 63:34
  assign sq_t    = sq_res + sq_bit;
  assign div_sum = {prod[39:0], 24'h000000} + {8'h00, div_lo};

  // window bounds and clipping
  assign k16   = wide ? 33'sd1310720 : 33'sd65536;
  assign w_eff = (32'(image_width) >= MAX_WIDTH) ? 17'(MAX_WIDTH) : $signed(17'(image_width));
  assign h_eff = (32'(image_height) >= MAX_HEIGHT) ? 17'(MAX_HEIGHT)
                                                   : $signed(17'(image_height));
  assign clo_c = (clo < 0) ? 17'sd0 : clo;
  assign chi_c = (chi > w_eff - 17'sd1) ? w_eff - 17'sd1 : chi;
  assign rlo_c = (rlo < 0) ? 17'sd0 : rlo;
  assign rhi_c = (rhi > h_eff - 17'sd1) ? h_eff - 17'sd1 : rhi;

  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      colmask_next[c] = (CW'(c) >= col_lo) && (CW'(c) <= col_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      image_width  <= '0;
      image_height <= '0;
      root_x       <= '0;
      root_y       <= '0;
      inv_scale    <= '0;
      out_valid    <= 1'b0;
      pend         <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == ST_SCAN);
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data[9:0];
          REG_IMAGE_HEIGHT: image_height <= cfg_data[9:0];
          REG_ROOT_X:       root_x       <= $signed(cfg_data[10:0]);
          REG_ROOT_Y:       root_y       <= $signed(cfg_data[10:0]);
          REG_INV_SCALE:    inv_scale    <= cfg_data;
          default:          ;
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (load_out) begin
      inside_res <= hit;
    end
    if (pend && |(rd_data & colmask)) begin
      hit <= 1'b1;
    end
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ax      <= point_x[23] ? 24'(-point_x) : 24'(point_x);
          ay      <= point_y[23] ? 24'(-point_y) : 24'(point_y);
          az      <= point_z[23] ? 24'(-point_z) : 24'(point_z);
          xneg    <= point_x[23];
          zpos    <= !point_z[23] && point_z != 24'sd0;
          revolve <= cmd == CMD_REVOLVE;
          wide    <= lenient;
          hit     <= 1'b0;
        end
      end
      ST_SQ_Y: begin
        sum   <= prod[47:0];
        y_big <= ay > ax;
      end
      ST_SQ_ADD: begin
        sq_n   <= {sum + prod[47:0], 16'h0000};
        sq_res <= '0;
        sq_bit <= 64'h4000_0000_0000_0000;
        cnt    <= '0;
      end
      ST_ROOT: begin
        if (sq_n >= sq_t) begin
          sq_n   <= sq_n - sq_t;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        cnt    <= cnt + 6'd1;
      end
      ST_PREP:    r <= sq_res[31:0];
      ST_DIV_HI:  div_lo <= prod;
      ST_DIV_SUM: r <= r + 32'(div_sum[63:34]);
      ST_MUL_V:   um <= revolve ? prod[55:16] : prod[47:8];
      ST_PLACE: begin
        u <= place_q16(um, xneg, root_x);
        v <= place_q16(prod[47:8], zpos, root_y);
      end
      ST_WIN: begin
        clo <= trunc16(33'(u) - k16);
        chi <= trunc16(33'(u) + k16);
        rlo <= trunc16(33'(v) - k16);
        rhi <= trunc16(33'(v) + k16);
      end
      ST_CLIP: begin
        col_lo  <= clo_c[CW-1:0];
        col_hi  <= chi_c[CW-1:0];
        row_ptr <= rlo_c[RW-1:0];
        row_hi  <= rhi_c[RW-1:0];
      end
      ST_MASK: colmask <= colmask_next;
      ST_SCAN: row_ptr <= row_ptr + RW'(1);
      default: ;
    endcase
  end

`ifndef SYNTH
  a_write_idle : assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> state == ST_IDLE)
    else $error("mask write outside idle");

  a_result_from_finish : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result loaded outside finish");

  a_scan_bounds : assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> row_ptr <= row_hi)
    else $error("row scan overran window");

  a_flush_after_scan : assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH |-> pend && $past(state == ST_SCAN))
    else $error("flush without pending row");
`endif

endmodule
